// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the integrator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/llgh_pkg.sv =====
// Package of the LLG Heun integrator: beat types and register indexes.
`timescale 1ns / 1ps
package llgh_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_PRECESSION = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING    = 1'd1;

  typedef struct packed {
    logic               func;
    logic [11:0]        spin_index;
    logic signed [15:0] spin_x;
    logic signed [15:0] spin_y;
    logic signed [15:0] spin_z;
    logic signed [23:0] field_x;
    logic signed [23:0] field_y;
    logic signed [23:0] field_z;
  } in_t;

  typedef struct packed {
    logic [11:0]        out_index;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic signed [15:0] new_z;
  } out_t;

endpackage

// ===== hw/rtl/llgh_ram.sv =====
// Generic single-port RAM with registered read and enable.
`timescale 1ns / 1ps
module llgh_ram #(
  parameter int Width = 48,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write or read; read data holds while disabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/llg_heun_spin_integrator_top.sv =====
// Top level of the fixed-point LLG Heun spin integrator.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One beat is accepted per clock cycle when the output side keeps up. The
// pipeline holds 51 stages and one output register: nine stages of torque
// arithmetic, store access and squares, 26 for the sum of squares and the
// square root, and 16 for the division. The whole pipeline stalls together
// while a result waits.
// Old spin and predictor step live in two single-port RAMs that are read and
// written in the same stage, so a corrector always sees the entry of any
// predictor ahead of it. A corrector for an entry never written returns an
// undefined result. The store slot is spin_index modulo SPIN_COUNT.
module llg_heun_spin_integrator_top #(
  parameter int SPIN_COUNT = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  llgh_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output llgh_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [llgh_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [llgh_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import llgh_pkg::*;

  localparam int AW     = (SPIN_COUNT > 1) ? $clog2(SPIN_COUNT) : 1;
  localparam int SQ_N   = 25;
  localparam int DIV_N  = 15;
  localparam int V_SQ0  = 9;
  localparam int V_DV0  = V_SQ0 + SQ_N + 1;
  localparam int NST    = V_DV0 + DIV_N + 1;

  typedef struct packed {
    logic             func;
    logic [11:0]      idx;
    logic [11:0]      slot;
    logic [2:0][15:0] s;
  } tag_t;

  // one conditional subtract of the slot reduction
  function automatic logic [11:0] mod_step(input logic [11:0] r, input int k);
    logic [43:0] lim;
    logic [43:0] rw;
    lim = 44'(SPIN_COUNT) << k;
    rw  = {32'd0, r};
    if (rw >= lim) begin
      mod_step = 12'(rw - lim);
    end else begin
      mod_step = r;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  // configuration
  logic [23:0] c1_q, c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PRECESSION: c1_q <= cfg_data_i;
        REG_DAMPING:    c2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance and valid chain
  logic           adv;
  logic [NST-1:0] vld_q;
  logic           out_valid_q;
  out_t           out_data_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NST-2:0], in_valid_i};
      out_valid_q <= vld_q[NST-1];
    end
  end

  // tags of stages 1..7
  tag_t tag_q [1:7];
  tag_t tag_d [1:7];

  always_comb begin
    tag_d[1].func = in_data_i.func;
    tag_d[1].idx  = in_data_i.spin_index;
    tag_d[1].slot = mod_step(mod_step(in_data_i.spin_index, 11), 10);
    tag_d[1].s[0] = in_data_i.spin_x;
    tag_d[1].s[1] = in_data_i.spin_y;
    tag_d[1].s[2] = in_data_i.spin_z;
    for (int j = 2; j <= 6; j++) begin
      tag_d[j]      = tag_q[j-1];
      tag_d[j].slot = mod_step(mod_step(tag_q[j-1].slot, 13 - 2*j), 12 - 2*j);
    end
    tag_d[7] = tag_q[6];
  end

  // stage 1: s x H partial products
  logic signed [15:0] s_in [3];
  logic signed [23:0] h_in [3];
  logic signed [39:0] m1_d [3][2];
  logic signed [39:0] m1_q [3][2];

  always_comb begin
    s_in[0] = in_data_i.spin_x;
    s_in[1] = in_data_i.spin_y;
    s_in[2] = in_data_i.spin_z;
    h_in[0] = in_data_i.field_x;
    h_in[1] = in_data_i.field_y;
    h_in[2] = in_data_i.field_z;
    for (int i = 0; i < 3; i++) begin
      m1_d[i][0] = s_in[(i+1)%3] * h_in[(i+2)%3];
      m1_d[i][1] = s_in[(i+2)%3] * h_in[(i+1)%3];
    end
  end

  // stage 2: p14 = round(p / 2^15)
  logic signed [40:0] p2   [3];
  logic signed [40:0] p2r  [3];
  logic signed [25:0] p14_d[3];
  logic signed [25:0] p14_q[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p2[i]    = $signed({m1_q[i][0][39], m1_q[i][0]}) - $signed({m1_q[i][1][39], m1_q[i][1]});
      p2r[i]   = (p2[i] + 41'sd16384) >>> 15;
      p14_d[i] = p2r[i][25:0];
    end
  end

  // stage 3: s x p14 partial products
  logic signed [41:0] m3_d  [3][2];
  logic signed [41:0] m3_q  [3][2];
  logic signed [25:0] p14b_q[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m3_d[i][0] = $signed(tag_q[2].s[(i+1)%3]) * p14_q[(i+2)%3];
      m3_d[i][1] = $signed(tag_q[2].s[(i+2)%3]) * p14_q[(i+1)%3];
    end
  end

  // stage 4: q14 = round(q / 2^14)
  logic signed [42:0] q4   [3];
  logic signed [42:0] q4r  [3];
  logic signed [28:0] q14_d[3];
  logic signed [28:0] q14_q[3];
  logic signed [25:0] p14c_q[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q4[i]    = $signed({m3_q[i][0][41], m3_q[i][0]}) - $signed({m3_q[i][1][41], m3_q[i][1]});
      q4r[i]   = (q4[i] + 43'sd8192) >>> 14;
      q14_d[i] = q4r[i][28:0];
    end
  end

  // stage 5: coefficient products
  logic signed [50:0] a_d [3];
  logic signed [53:0] b_d [3];
  logic signed [50:0] a_q [3];
  logic signed [53:0] b_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i] = $signed({1'b0, c1_q}) * p14c_q[i];
      b_d[i] = $signed({1'b0, c2_q}) * q14_q[i];
    end
  end

  // stage 6: d = -c1*p14 - c2*q14
  logic signed [55:0] d_d [3];
  logic signed [55:0] d_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = -$signed({{5{a_q[i][50]}}, a_q[i]}) - $signed({{2{b_q[i][53]}}, b_q[i]});
    end
  end

  // stage 7: predictor step and store access
  logic signed [55:0] dr7   [3];
  logic signed [15:0] step_d[3];
  logic signed [15:0] step_q[3];
  logic signed [55:0] d7_q  [3];
  logic [47:0]        step_wr;
  logic [47:0]        old_rd, step_rd;
  logic               ram_we;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dr7[i]    = (d_q[i] + 56'sd8388608) >>> 24;
      step_d[i] = sat16(dr7[i][39:0]);
      step_wr[16*i +: 16] = step_d[i];
    end
  end

  assign ram_we = adv && vld_q[5] && !tag_q[6].func;

  llgh_ram #(
    .Width (48),
    .Depth (SPIN_COUNT)
  ) u_old_ram (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (ram_we),
    .addr_i  (AW'(tag_q[6].slot)),
    .wdata_i (tag_q[6].s),
    .rdata_o (old_rd)
  );

  llgh_ram #(
    .Width (48),
    .Depth (SPIN_COUNT)
  ) u_step_ram (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (ram_we),
    .addr_i  (AW'(tag_q[6].slot)),
    .wdata_i (step_wr),
    .rdata_o (step_rd)
  );

  // stage 8: Heun average and unnormalised spin
  logic signed [15:0] f8  [3];
  logic signed [15:0] o8  [3];
  logic signed [63:0] t8  [3];
  logic signed [63:0] t8r [3];
  logic signed [15:0] stc8[3];
  logic signed [16:0] e_d [3];
  logic signed [16:0] e_q [3];
  logic [11:0]        idx8_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f8[i]   = step_rd[16*i +: 16];
      o8[i]   = old_rd[16*i +: 16];
      t8[i]   = $signed({{24{f8[i][15]}}, f8[i], 24'd0}) + $signed({{8{d7_q[i][55]}}, d7_q[i]});
      t8r[i]  = (t8[i] + 64'sd16777216) >>> 25;
      stc8[i] = sat16(t8r[i][39:0]);
      if (tag_q[7].func) begin
        e_d[i] = $signed({o8[i][15], o8[i]}) + $signed({stc8[i][15], stc8[i]});
      end else begin
        e_d[i] = $signed({tag_q[7].s[i][15], tag_q[7].s[i]})
               + $signed({step_q[i][15], step_q[i]});
      end
    end
  end

  // stage 9: squares
  logic signed [33:0] sqp [3];
  logic [32:0]        sq_q[3];
  logic signed [16:0] e9_q[3];
  logic [11:0]        idx9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqp[i] = e_q[i] * e_q[i];
    end
  end

  // square root pipeline, one result bit a stage
  logic [50:0]        sqn_d [SQ_N+1];
  logic [50:0]        sqr_d [SQ_N+1];
  logic [50:0]        sqn_q [SQ_N+1];
  logic [50:0]        sqr_q [SQ_N+1];
  logic signed [16:0] sqe_q [SQ_N+1][3];
  logic [11:0]        sqi_q [SQ_N+1];
  logic [33:0]        msum;
  logic [50:0]        trial [SQ_N+1];

  always_comb begin
    msum     = {1'b0, sq_q[0]} + {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
    sqn_d[0] = {1'b0, msum, 16'd0};
    sqr_d[0] = '0;
    trial[0] = '0;
    for (int j = 1; j <= SQ_N; j++) begin
      trial[j] = sqr_q[j-1] + (51'd1 << (2*(SQ_N-j)));
      if (sqn_q[j-1] >= trial[j]) begin
        sqn_d[j] = sqn_q[j-1] - trial[j];
        sqr_d[j] = (sqr_q[j-1] >> 1) + (51'd1 << (2*(SQ_N-j)));
      end else begin
        sqn_d[j] = sqn_q[j-1];
        sqr_d[j] = sqr_q[j-1] >> 1;
      end
    end
  end

  // division pipeline: e*2^22 / r rounded, one quotient bit a stage
  logic [24:0]  rt;
  logic [16:0]  mag  [3];
  logic [40:0]  rem_d[DIV_N+1][3];
  logic [40:0]  rem_q[DIV_N+1][3];
  logic [14:0]  quo_d[DIV_N+1][3];
  logic [14:0]  quo_q[DIV_N+1][3];
  logic [25:0]  dv_q [DIV_N+1];
  logic [2:0]   neg_q[DIV_N+1];
  logic         zr_q [DIV_N+1];
  logic [11:0]  dvi_q[DIV_N+1];
  logic [2:0]   neg_d0;
  logic [40:0]  dsh  [DIV_N+1];

  always_comb begin
    rt = sqr_q[SQ_N][24:0];
    dsh[0] = '0;
    for (int i = 0; i < 3; i++) begin
      neg_d0[i]   = sqe_q[SQ_N][i][16];
      mag[i]      = neg_d0[i] ? 17'(-sqe_q[SQ_N][i]) : 17'(sqe_q[SQ_N][i]);
      rem_d[0][i] = {1'b0, mag[i], 23'd0} + {16'd0, rt};
      quo_d[0][i] = '0;
    end
    for (int j = 1; j <= DIV_N; j++) begin
      dsh[j] = {15'd0, dv_q[j-1]} << (DIV_N - j);
      for (int i = 0; i < 3; i++) begin
        quo_d[j][i] = quo_q[j-1][i];
        if (rem_q[j-1][i] >= dsh[j]) begin
          rem_d[j][i] = rem_q[j-1][i] - dsh[j];
          quo_d[j][i][DIV_N-j] = 1'b1;
        end else begin
          rem_d[j][i] = rem_q[j-1][i];
        end
      end
    end
  end

  // result signs and zero vector
  logic signed [15:0] nv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zr_q[DIV_N]) begin
        nv[i] = '0;
      end else if (neg_q[DIV_N][i]) begin
        nv[i] = -$signed({1'b0, quo_q[DIV_N][i]});
      end else begin
        nv[i] = $signed({1'b0, quo_q[DIV_N][i]});
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 1; j <= 7; j++) begin
        tag_q[j] <= tag_d[j];
      end
      for (int i = 0; i < 3; i++) begin
        m1_q[i]   <= m1_d[i];
        p14_q[i]  <= p14_d[i];
        m3_q[i]   <= m3_d[i];
        p14b_q[i] <= p14_q[i];
        q14_q[i]  <= q14_d[i];
        p14c_q[i] <= p14b_q[i];
        a_q[i]    <= a_d[i];
        b_q[i]    <= b_d[i];
        d_q[i]    <= d_d[i];
        d7_q[i]   <= d_q[i];
        step_q[i] <= step_d[i];
        e_q[i]    <= e_d[i];
        sq_q[i]   <= sqp[i][32:0];
        e9_q[i]   <= e_q[i];
      end
      idx8_q <= tag_q[7].idx;
      idx9_q <= idx8_q;

      for (int j = 0; j <= SQ_N; j++) begin
        sqn_q[j] <= sqn_d[j];
        sqr_q[j] <= sqr_d[j];
      end
      sqe_q[0] <= e9_q;
      sqi_q[0] <= idx9_q;
      for (int j = 1; j <= SQ_N; j++) begin
        sqe_q[j] <= sqe_q[j-1];
        sqi_q[j] <= sqi_q[j-1];
      end

      for (int j = 0; j <= DIV_N; j++) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
      end
      dv_q[0]  <= {rt, 1'b0};
      neg_q[0] <= neg_d0;
      zr_q[0]  <= (rt == '0);
      dvi_q[0] <= sqi_q[SQ_N];
      for (int j = 1; j <= DIV_N; j++) begin
        dv_q[j]  <= dv_q[j-1];
        neg_q[j] <= neg_q[j-1];
        zr_q[j]  <= zr_q[j-1];
        dvi_q[j] <= dvi_q[j-1];
      end

      out_data_q.out_index <= dvi_q[DIV_N];
      out_data_q.new_x     <= nv[0];
      out_data_q.new_y     <= nv[1];
      out_data_q.new_z     <= nv[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `ASSERT_NEXT(a_store_stage_flow, adv && vld_q[5], vld_q[6], "beat lost at store stage")
  `ASSERT_NEXT(a_freeze, !adv, $stable(vld_q), "pipeline moved while stalled")
  `ASSERT_AT(a_out_source, $rose(out_valid_o) |-> $past(vld_q[NST-1]), "result from empty stage")

endmodule
